// File: sv/gtj_pkg.sv
// Shared types and constants for the greedy text justifier.
`timescale 1ns / 1ps
`default_nettype none

package gtj_pkg;

    // Width of a word length, a line width and a space count.
    localparam int WORD_W     = 7;
    // Stream data widths, rounded up to whole bytes, and the result user width.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    localparam logic [WORD_W-1:0] WIDTH_RESET = 7'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FL_PREP,
        ST_FL_DIV,
        ST_FL_RD,
        ST_FL_OUT,
        ST_APPEND,
        ST_LONG
    } gtj_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gtj_div_stat_t;

endpackage

`default_nettype wire

// File: sv/gtj_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gtj_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/gtj_div.sv
// Restoring divider, one quotient bit per cycle, for sharing spare spaces among gaps.
`timescale 1ns / 1ps
`default_nettype none

module gtj_div
    import gtj_pkg::*;
#(
    parameter int DIVR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output gtj_div_stat_t          stat,
    output logic      [WORD_W-1:0] quotient,
    output logic      [DIVR_W-1:0] remainder
);

    localparam int STEP_W = $clog2(WORD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quo_reg[WORD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            quo_next  = {quo_reg[WORD_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: sv/greedy_text_justifier.sv
// Top level of the greedy text justifier: sequencer, line buffer, divider and output register.
//
// The block packs a stream of word lengths greedily into lines of line_width
// characters and, whenever a line closes, sends one result per word of it.
// Input requests arrive on s_tvalid/s_tready/s_tdata with s_tlast marking
// the final word of the text. Results leave on m_tvalid/m_tready/m_tdata,
// with m_tuser carrying line_end and too_long and m_tlast marking the last
// result caused by one input request. The line width is written through
// cfg_valid/cfg_ready/cfg_data, which is always ready; write it only while
// the block is idle.
//
// One input request is taken at a time; s_tready is high only in the idle
// state. A word that just joins the open line passes through the decide and
// append states. Closing a line takes a setup state, then, when a full line
// has at least one gap, the bit-serial divider, then a read and an output
// state per word, from the registered read of the line buffer RAM. A
// stalled receiver simply holds the sequencer at the output register;
// nothing is dropped. Reset (aresetn low, synchronous) empties the line,
// clears the output valid flag and sets the line width to 16.
`timescale 1ns / 1ps
`default_nettype none

module greedy_text_justifier
    import gtj_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 64,
    parameter int MAX_LINE_WORDS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write: cfg_data is line_width.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [WORD_W-1:0]     cfg_data,
    // Input words.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [6:0] word_length, [7] zero
    input  wire logic                  s_tlast,   // final_word
    // Results.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [6:0] out_word_length,
                                                  // [13:7] spaces_after, [15:14] zero
    output logic [OUT_USER_W-1:0]      m_tuser,   // [0] line_end, [1] too_long
    output logic                       m_tlast    // run_last
);

    // Count of buffered words must reach MAX_LINE_WORDS; the RAM index need not.
    localparam int CNT_W = $clog2(MAX_LINE_WORDS + 1);
    localparam int IDX_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
    localparam logic [WORD_W-1:0] MAX_W     = WORD_W'(MAX_LINE_WIDTH);
    localparam logic [CNT_W-1:0]  MAX_WORDS = CNT_W'(MAX_LINE_WORDS);

    gtj_state_t state_reg, state_next;

    logic [WORD_W-1:0] width_reg;
    logic [WORD_W-1:0] len_reg, len_next;
    logic              fin_reg, fin_next;
    logic              last_mode_reg, last_mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] spare_reg, spare_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0] out_len_reg, out_len_next;
    logic [WORD_W-1:0] out_sp_reg, out_sp_next;
    logic              out_end_reg, out_end_next;
    logic              out_long_reg, out_long_next;
    logic              out_last_reg, out_last_next;

    logic [WORD_W-1:0] eff_w;
    logic              long_c;
    logic              fit_fail;
    logic              need_flush;
    logic [CNT_W-1:0]  gaps;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] spare_c;
    logic              div_start;
    logic              slot_free;
    logic              is_end;
    logic [WORD_W-1:0] sp_out;
    logic              out_load;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    gtj_div_stat_t     div_stat;
    logic [WORD_W-1:0] div_quo;
    logic [CNT_W-1:0]  div_rem;

    // The width register is clamped to 1..MAX_LINE_WIDTH on use, so zero acts as 1.
    always_comb begin
        if (width_reg == '0) begin
            eff_w = WORD_W'(1);
        end else if (width_reg > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = width_reg;
        end
    end

    // Decision terms; the sum needs one extra bit before the compare.
    assign long_c     = (len_reg > eff_w);
    assign fit_fail   = (({1'b0, used_reg} + 8'd1 + {1'b0, len_reg}) > {1'b0, eff_w});
    assign need_flush = (count_reg != '0) &&
                        (long_c || fit_fail || (count_reg >= MAX_WORDS));

    // A full line shares w minus the bare word lengths; a last line only pads
    // the tail. Either value clamps at zero when the width was narrowed.
    assign gaps    = count_reg - CNT_W'(1);
    assign base    = last_mode_reg ? used_reg : (used_reg - WORD_W'(gaps));
    assign spare_c = (base < eff_w) ? (eff_w - base) : '0;

    assign div_start = (state_reg == ST_FL_PREP) && !last_mode_reg && (gaps != '0);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign is_end    = (idx_reg == gaps);

    // Spaces after the word at idx_reg while a line is being sent.
    always_comb begin
        if (last_mode_reg) begin
            sp_out = is_end ? spare_reg : WORD_W'(1);
        end else if (is_end) begin
            sp_out = (gaps == '0) ? spare_reg : '0;
        end else begin
            sp_out = div_quo + ((idx_reg < div_rem) ? WORD_W'(1) : WORD_W'(0));
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (need_flush) begin
                    state_next = ST_FL_PREP;
                end else if (long_c) begin
                    state_next = ST_LONG;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_FL_PREP: begin
                state_next = div_start ? ST_FL_DIV : ST_FL_RD;
            end
            ST_FL_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_FL_RD;
                end
            end
            ST_FL_RD: begin
                state_next = ST_FL_OUT;
            end
            ST_FL_OUT: begin
                if (slot_free) begin
                    priority if (!is_end) begin
                        state_next = ST_FL_RD;
                    end else if (last_mode_reg) begin
                        state_next = ST_IDLE;
                    end else if (long_c) begin
                        state_next = ST_LONG;
                    end else begin
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_APPEND: begin
                state_next = fin_reg ? ST_FL_PREP : ST_IDLE;
            end
            ST_LONG: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and strobes per state.
    always_comb begin
        len_next       = len_reg;
        fin_next       = fin_reg;
        last_mode_next = last_mode_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        spare_next     = spare_reg;
        out_len_next   = out_len_reg;
        out_sp_next    = out_sp_reg;
        out_end_next   = out_end_reg;
        out_long_next  = out_long_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    len_next = s_tdata[WORD_W-1:0];
                    fin_next = s_tlast;
                end
            end
            ST_DECIDE: begin
                last_mode_next = 1'b0;
            end
            ST_FL_PREP: begin
                idx_next   = '0;
                spare_next = spare_c;
            end
            ST_FL_DIV: begin
            end
            ST_FL_RD: begin
                ram_re = 1'b1;
            end
            ST_FL_OUT: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_len_next  = ram_rdata;
                    out_sp_next   = sp_out;
                    out_end_next  = is_end;
                    out_long_next = 1'b0;
                    // Nothing follows a last line; a full line is followed by
                    // output only for a long word or a final word.
                    out_last_next = is_end && (last_mode_reg || !(long_c || fin_reg));
                    if (is_end) begin
                        count_next = '0;
                        used_next  = '0;
                    end else begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_APPEND: begin
                ram_we         = 1'b1;
                used_next      = used_reg + len_reg +
                                 ((count_reg != '0) ? WORD_W'(1) : WORD_W'(0));
                count_next     = count_reg + CNT_W'(1);
                last_mode_next = 1'b1;
            end
            ST_LONG: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_len_next  = len_reg;
                    out_sp_next   = '0;
                    out_end_next  = 1'b1;
                    out_long_next = 1'b1;
                    out_last_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= WIDTH_RESET;
            count_reg    <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                width_reg <= cfg_data;
            end
        end
        len_reg       <= len_next;
        fin_reg       <= fin_next;
        last_mode_reg <= last_mode_next;
        idx_reg       <= idx_next;
        spare_reg     <= spare_next;
        out_len_reg   <= out_len_next;
        out_sp_reg    <= out_sp_next;
        out_end_reg   <= out_end_next;
        out_long_reg  <= out_long_next;
        out_last_reg  <= out_last_next;
    end

    // Words of the open line.
    gtj_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_LINE_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (len_reg),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Spare spaces divided among the gaps of a full line.
    gtj_div #(
        .DIVR_W (CNT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (spare_c),
        .divisor   (gaps),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OUT_DATA_W - 2 * WORD_W){1'b0}}, out_sp_reg, out_len_reg};
    assign m_tuser   = {out_long_reg, out_end_reg};
    assign m_tlast   = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_WORDS)
        else $error("line word count beyond buffer depth");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= MAX_W)
        else $error("used line width beyond maximum width");

    a_long_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_long_reg |-> out_end_reg && out_last_reg && (out_sp_reg == '0))
        else $error("too-long word not placed alone");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_last_reg |-> out_end_reg)
        else $error("last result of a request does not end a line");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken before the first was handled");
`endif

endmodule

`default_nettype wire
